>>> hw/rtl/adr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ArtDmx receiver package
// Shared constants, codes and types of the ArtDmx packet receiver.
// ----------------------------------------------------------------------------
package adr_pkg;

   localparam int CHANNELS         = 512;
   localparam int MAX_PACKET_BYTES = 530;
   localparam int HEADER_BYTES     = 18;

   localparam int POS_W   = 10;
   localparam int CH_W    = 9;
   localparam int ADDR_W  = CH_W + 1;
   localparam int LEN_W   = 10;
   localparam int UNIV_W  = 15;

   localparam logic [15:0] OPCODE_DMX = 16'h5000;

   localparam logic [POS_W-1:0] POS_ID_END  = POS_W'(7);
   localparam logic [POS_W-1:0] POS_OP_LO   = POS_W'(8);
   localparam logic [POS_W-1:0] POS_OP_HI   = POS_W'(9);
   localparam logic [POS_W-1:0] POS_UNIV_LO = POS_W'(14);
   localparam logic [POS_W-1:0] POS_UNIV_HI = POS_W'(15);
   localparam logic [POS_W-1:0] POS_LEN_HI  = POS_W'(16);
   localparam logic [POS_W-1:0] POS_LEN_LO  = POS_W'(17);

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_READ = 1'b1
   } adr_op_type;

   typedef enum logic [2:0] {
      REASON_ACCEPT         = 3'd0,
      REASON_SHORT          = 3'd1,
      REASON_BAD_ID         = 3'd2,
      REASON_BAD_OPCODE     = 3'd3,
      REASON_OTHER_UNIVERSE = 3'd4,
      REASON_TRUNCATED      = 3'd5
   } adr_reason_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } adr_wr_type;

   typedef struct packed {
      logic             valid;
      logic             done;
      adr_reason_type   reason;
      logic [LEN_W-1:0] frame_length;
      logic             active;
      logic             zero;
   } adr_result_type;

   function automatic logic [7:0] id_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h41;
         3'd1:    c = 8'h72;
         3'd2:    c = 8'h74;
         3'd3:    c = 8'h2D;
         3'd4:    c = 8'h4E;
         3'd5:    c = 8'h65;
         3'd6:    c = 8'h74;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/adr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ArtDmx receiver channels
// Valid/ready request and response channels of the receiver.
// ----------------------------------------------------------------------------
interface adr_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] data_byte;
   logic       last_byte;
   logic [8:0] channel_index;

   modport source(output valid, output operation, output data_byte,
                  output last_byte, output channel_index, input ready);
   modport sink(input valid, input operation, input data_byte,
                input last_byte, input channel_index, output ready);
endinterface

interface adr_rsp_if;
   logic       valid;
   logic       ready;
   logic       packet_done;
   logic [2:0] reject_reason;
   logic [9:0] frame_length;
   logic [7:0] channel_value;
   logic       receiver_active;

   modport source(output valid, output packet_done, output reject_reason,
                  output frame_length, output channel_value,
                  output receiver_active, input ready);
   modport sink(input valid, input packet_done, input reject_reason,
                input frame_length, input channel_value,
                input receiver_active, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/adr_frame_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ArtDmx frame store
// Two banks of channel bytes, one write port, one registered read port.
// ----------------------------------------------------------------------------
module adr_frame_store (
   input  wire                          clock,
   input  wire adr_pkg::adr_wr_type     wr,
   input  wire                          rd_en,
   input  wire [adr_pkg::ADDR_W-1:0]    rd_addr,
   output logic [7:0]                   rd_data
);

   logic [7:0] mem [0:(1 << adr_pkg::ADDR_W)-1];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> hw/rtl/adr_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ArtDmx packet parser
// Header checks, channel write address, bank swap and live frame state.
// ----------------------------------------------------------------------------
module adr_parser (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              take,
   input  wire                              operation,
   input  wire [7:0]                        data_byte,
   input  wire                              last_byte,
   input  wire [adr_pkg::CH_W-1:0]          channel_index,
   input  wire [adr_pkg::UNIV_W-1:0]        listen_universe,
   output adr_pkg::adr_wr_type              wr,
   output logic                             rd_en,
   output logic [adr_pkg::ADDR_W-1:0]       rd_addr,
   output adr_pkg::adr_result_type          result
);

   logic [adr_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic                       id_ok_ff, id_ok_in;
   logic [15:0]                opcode_ff, opcode_in;
   logic [adr_pkg::UNIV_W-1:0] universe_ff, universe_in;
   logic [15:0]                dlen_ff, dlen_in;
   logic                       live_bank_ff, live_bank_in;
   logic [adr_pkg::LEN_W-1:0]  live_length_ff, live_length_in;
   logic                       active_ff, active_in;

   logic                       in_range;
   logic [adr_pkg::POS_W-1:0]  ch_pos;
   logic [adr_pkg::POS_W-1:0]  len;
   logic [adr_pkg::LEN_W-1:0]  dlen_cap;
   logic [adr_pkg::LEN_W:0]    need;
   adr_pkg::adr_reason_type    reason;
   logic                       is_byte;

   always_comb begin
      is_byte  = (adr_pkg::adr_op_type'(operation) == adr_pkg::OP_BYTE);
      in_range = (pos_ff < adr_pkg::POS_W'(adr_pkg::MAX_PACKET_BYTES));
      ch_pos   = pos_ff - adr_pkg::POS_W'(adr_pkg::HEADER_BYTES);

      id_ok_in    = id_ok_ff;
      opcode_in   = opcode_ff;
      universe_in = universe_ff;
      dlen_in     = dlen_ff;
      wr.en       = 1'b0;
      wr.addr     = {~live_bank_ff, ch_pos[adr_pkg::CH_W-1:0]};
      wr.data     = data_byte;

      if (in_range) begin
         if (pos_ff < adr_pkg::POS_ID_END) begin
            if (data_byte != adr_pkg::id_char(pos_ff[2:0])) begin
               id_ok_in = 1'b0;
            end
         end else if (pos_ff == adr_pkg::POS_OP_LO) begin
            opcode_in = {opcode_ff[15:8], data_byte};
         end else if (pos_ff == adr_pkg::POS_OP_HI) begin
            opcode_in = {data_byte, opcode_ff[7:0]};
         end else if (pos_ff == adr_pkg::POS_UNIV_LO) begin
            universe_in = {universe_ff[14:8], data_byte};
         end else if (pos_ff == adr_pkg::POS_UNIV_HI) begin
            universe_in = {data_byte[6:0], universe_ff[7:0]};
         end else if (pos_ff == adr_pkg::POS_LEN_HI) begin
            dlen_in = {data_byte, dlen_ff[7:0]};
         end else if (pos_ff == adr_pkg::POS_LEN_LO) begin
            dlen_in = {dlen_ff[15:8], data_byte};
         end else if (pos_ff >= adr_pkg::POS_W'(adr_pkg::HEADER_BYTES)) begin
            wr.en = (ch_pos < adr_pkg::POS_W'(adr_pkg::CHANNELS));
         end
      end
      wr.en = wr.en && take && is_byte;

      len      = in_range ? pos_ff + 1'b1 : pos_ff;
      dlen_cap = (dlen_in > 16'(adr_pkg::CHANNELS)) ?
                 adr_pkg::LEN_W'(adr_pkg::CHANNELS) : dlen_in[adr_pkg::LEN_W-1:0];
      need     = (adr_pkg::LEN_W+1)'(adr_pkg::HEADER_BYTES) + {1'b0, dlen_cap};

      if (len < adr_pkg::POS_W'(adr_pkg::HEADER_BYTES)) begin
         reason = adr_pkg::REASON_SHORT;
      end else if (!id_ok_in) begin
         reason = adr_pkg::REASON_BAD_ID;
      end else if (opcode_in != adr_pkg::OPCODE_DMX) begin
         reason = adr_pkg::REASON_BAD_OPCODE;
      end else if (universe_in != listen_universe) begin
         reason = adr_pkg::REASON_OTHER_UNIVERSE;
      end else if ({1'b0, len} < need) begin
         reason = adr_pkg::REASON_TRUNCATED;
      end else begin
         reason = adr_pkg::REASON_ACCEPT;
      end

      pos_in         = len;
      live_bank_in   = live_bank_ff;
      live_length_in = live_length_ff;
      active_in      = active_ff;
      if (last_byte) begin
         pos_in      = '0;
         id_ok_in    = 1'b1;
         opcode_in   = '0;
         universe_in = '0;
         dlen_in     = '0;
         if (reason == adr_pkg::REASON_ACCEPT) begin
            live_bank_in   = ~live_bank_ff;
            live_length_in = dlen_cap;
            active_in      = 1'b1;
         end
      end

      rd_en   = take && !is_byte;
      rd_addr = {live_bank_ff, channel_index};

      result.valid        = !is_byte || last_byte;
      result.done         = is_byte;
      result.reason       = is_byte ? reason : adr_pkg::REASON_ACCEPT;
      result.frame_length = is_byte ? live_length_in : live_length_ff;
      result.active       = is_byte ? active_in : active_ff;
      result.zero         = is_byte ||
                            ({1'b0, channel_index} >= live_length_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         id_ok_ff       <= 1'b1;
         opcode_ff      <= '0;
         universe_ff    <= '0;
         dlen_ff        <= '0;
         live_bank_ff   <= 1'b0;
         live_length_ff <= '0;
         active_ff      <= 1'b0;
      end else if (take && is_byte) begin
         pos_ff         <= pos_in;
         id_ok_ff       <= id_ok_in;
         opcode_ff      <= opcode_in;
         universe_ff    <= universe_in;
         dlen_ff        <= dlen_in;
         live_bank_ff   <= live_bank_in;
         live_length_ff <= live_length_in;
         active_ff      <= active_in;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/artdmx_packet_receiver_unit.sv
// A read or packet-end item's result passes through stage one and stage two;
// bytes that do not end a packet give no result. Items go in at one per cycle
// while the response side drains, set by the single frame store port pair.
// Two result stages let one more item in while a result waits.
// Reset is synchronous; the frame store holds no reset and needs no sweep.
`default_nettype none
// ----------------------------------------------------------------------------
// ArtDmx packet receiver
// Parses ArtDmx packets into a double-buffered frame and serves channel reads.
// ----------------------------------------------------------------------------
module artdmx_packet_receiver_unit (
   input  wire                         clock,
   input  wire                         reset,
   adr_req_if.sink                     req_ch,
   adr_rsp_if.source                   rsp_ch,
   input  wire                         csr_wr_en,
   input  wire [adr_pkg::UNIV_W-1:0]   csr_wr_data
);

   logic [adr_pkg::UNIV_W-1:0] universe_ff;
   logic                       take;
   adr_pkg::adr_wr_type        wr;
   logic                       rd_en;
   logic [adr_pkg::ADDR_W-1:0] rd_addr;
   logic [7:0]                 rd_data;
   adr_pkg::adr_result_type    result;

   logic                       s1_valid_ff, s1_valid_in;
   adr_pkg::adr_result_type    s1_res_ff;
   logic                       s1_move;
   logic                       s2_valid_ff, s2_valid_in;
   logic                       s2_done_ff;
   logic [2:0]                 s2_reason_ff;
   logic [adr_pkg::LEN_W-1:0]  s2_length_ff;
   logic [7:0]                 s2_value_ff;
   logic                       s2_active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         universe_ff <= '0;
      end else if (csr_wr_en) begin
         universe_ff <= csr_wr_data;
      end
   end

   assign s1_move      = s1_valid_ff && (!s2_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_move;
   assign take         = req_ch.valid && req_ch.ready;

   adr_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .take            (take),
      .operation       (req_ch.operation),
      .data_byte       (req_ch.data_byte),
      .last_byte       (req_ch.last_byte),
      .channel_index   (req_ch.channel_index),
      .listen_universe (universe_ff),
      .wr              (wr),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .result          (result)
   );

   adr_frame_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = result.valid;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      if (s1_move) begin
         s2_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_res_ff <= result;
      end
      if (s1_move) begin
         s2_done_ff   <= s1_res_ff.done;
         s2_reason_ff <= s1_res_ff.reason;
         s2_length_ff <= s1_res_ff.frame_length;
         s2_value_ff  <= s1_res_ff.zero ? 8'h00 : rd_data;
         s2_active_ff <= s1_res_ff.active;
      end
   end

   assign rsp_ch.valid           = s2_valid_ff;
   assign rsp_ch.packet_done     = s2_done_ff;
   assign rsp_ch.reject_reason   = s2_reason_ff;
   assign rsp_ch.frame_length    = s2_length_ff;
   assign rsp_ch.channel_value   = s2_value_ff;
   assign rsp_ch.receiver_active = s2_active_ff;

`ifndef SYNTHESIS
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_valid_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("item accepted while both result stages are held");

   a_read_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.packet_done |->
         rsp_ch.reject_reason == adr_pkg::REASON_ACCEPT)
      else $error("read result carries a reject reason");

   a_idle_length: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.receiver_active |->
         rsp_ch.frame_length == '0 && rsp_ch.channel_value == 8'h00)
      else $error("inactive receiver reports frame data");
`endif

endmodule
`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// ArtDmx packet receiver testbench
// Streams ArtDmx packets and channel reads through the request channel with
// random idle cycles on both sides, predicts each result with a cycle-free
// model of the receiver, and checks every result field in order. Runs
// through several listen universes, including both extremes.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [55:0] ART_ID = "Art-Net";
   localparam int PHASE_ITEMS = 170;

   typedef struct {
      adr_pkg::adr_op_type op;
      logic [7:0] data_byte;
      logic       last_byte;
      logic [8:0] channel_index;
   } rx_item_type;

   typedef struct {
      logic                    done;
      adr_pkg::adr_reason_type reason;
      logic [9:0]              frame_length;
      logic [7:0]              channel_value;
      logic                    active;
   } rx_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic [adr_pkg::UNIV_W-1:0] csr_wr_data;

   adr_req_if req_ch();
   adr_rsp_if rsp_ch();

   artdmx_packet_receiver_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   rx_item_type   byte_stream[$];
   rx_report_type awaited_reports[$];
   int items_queued   = 0;
   int items_accepted = 0;
   int mismatches     = 0;
   int read_mix       = 0;

   int feed_gap    = 0;
   bit feed_calm   = 1'b0;
   int drain_stall = 0;
   bit drain_calm  = 1'b0;

   // receiver image
   logic [7:0]                 frame_copy [0:2*adr_pkg::CHANNELS-1];
   logic                       shadow_bank;
   logic [adr_pkg::LEN_W-1:0]  shadow_length;
   logic                       shadow_active;
   int                         pkt_pos;
   logic                       pkt_id_ok;
   logic [15:0]                pkt_opcode;
   logic [adr_pkg::UNIV_W-1:0] pkt_universe;
   logic [15:0]                pkt_declared;
   logic [adr_pkg::UNIV_W-1:0] listen_copy;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic void predict_item(input rx_item_type it);
      rx_report_type r;
      int cap;
      r.done = 1'b0;
      r.reason = adr_pkg::REASON_ACCEPT;
      r.channel_value = 8'h00;
      if (it.op == adr_pkg::OP_READ) begin
         if (it.channel_index < shadow_length)
            r.channel_value = frame_copy[{shadow_bank, it.channel_index}];
      end else begin
         if (pkt_pos < adr_pkg::MAX_PACKET_BYTES) begin
            if (pkt_pos < 7) begin
               if (it.data_byte != ART_ID[8*(6-pkt_pos) +: 8])
                  pkt_id_ok = 1'b0;
            end else if (pkt_pos == 8) begin
               pkt_opcode[7:0] = it.data_byte;
            end else if (pkt_pos == 9) begin
               pkt_opcode[15:8] = it.data_byte;
            end else if (pkt_pos == 14) begin
               pkt_universe[7:0] = it.data_byte;
            end else if (pkt_pos == 15) begin
               pkt_universe[14:8] = it.data_byte[6:0];
            end else if (pkt_pos == 16) begin
               pkt_declared[15:8] = it.data_byte;
            end else if (pkt_pos == 17) begin
               pkt_declared[7:0] = it.data_byte;
            end else if (pkt_pos >= adr_pkg::HEADER_BYTES) begin
               frame_copy[{~shadow_bank, 9'(pkt_pos - adr_pkg::HEADER_BYTES)}] = it.data_byte;
            end
            pkt_pos++;
         end
         if (!it.last_byte)
            return;
         cap = (pkt_declared > adr_pkg::CHANNELS) ? adr_pkg::CHANNELS : int'(pkt_declared);
         r.done = 1'b1;
         if (pkt_pos < adr_pkg::HEADER_BYTES)
            r.reason = adr_pkg::REASON_SHORT;
         else if (!pkt_id_ok)
            r.reason = adr_pkg::REASON_BAD_ID;
         else if (pkt_opcode != adr_pkg::OPCODE_DMX)
            r.reason = adr_pkg::REASON_BAD_OPCODE;
         else if (pkt_universe != listen_copy)
            r.reason = adr_pkg::REASON_OTHER_UNIVERSE;
         else if (pkt_pos < adr_pkg::HEADER_BYTES + cap)
            r.reason = adr_pkg::REASON_TRUNCATED;
         if (r.reason == adr_pkg::REASON_ACCEPT) begin
            shadow_bank = ~shadow_bank;
            shadow_length = adr_pkg::LEN_W'(cap);
            shadow_active = 1'b1;
         end
         pkt_pos = 0;
         pkt_id_ok = 1'b1;
         pkt_opcode = '0;
         pkt_universe = '0;
         pkt_declared = '0;
      end
      r.frame_length = shadow_length;
      r.active = shadow_active;
      awaited_reports.push_back(r);
   endfunction

   task automatic queue_read(input logic [8:0] idx);
      rx_item_type it;
      it.op = adr_pkg::OP_READ;
      it.data_byte = 8'($urandom);
      it.last_byte = 1'($urandom);
      it.channel_index = idx;
      byte_stream.push_back(it);
      items_queued++;
   endtask

   task automatic queue_byte(input logic [7:0] b, input logic last);
      rx_item_type it;
      logic [8:0] idx;
      if ($urandom_range(0, 99) < read_mix) begin
         case ($urandom_range(0, 3))
            0, 1:    idx = 9'($urandom_range(0, 31));
            2:       idx = 9'($urandom_range(480, 511));
            default: idx = 9'($urandom);
         endcase
         queue_read(idx);
      end
      it.op = adr_pkg::OP_BYTE;
      it.data_byte = b;
      it.last_byte = last;
      it.channel_index = 9'($urandom);
      byte_stream.push_back(it);
      items_queued++;
   endtask

   task automatic queue_packet(input int total, input logic [15:0] declared,
                               input logic [adr_pkg::UNIV_W-1:0] univ, input bit bad_id,
                               input bit bad_op);
      int spoil;
      logic [15:0] opcode;
      logic [7:0] b;
      spoil = $urandom_range(0, 6);
      opcode = adr_pkg::OPCODE_DMX;
      if (bad_op)
         opcode = opcode ^ (16'(1) << $urandom_range(0, 15)) ^ 16'($urandom_range(0, 1) << 3);
      for (int p = 0; p < total; p++) begin
         if (p < 7) begin
            b = ART_ID[8*(6-p) +: 8];
            if (bad_id && p == spoil)
               b = b ^ 8'($urandom_range(1, 255));
         end else begin
            case (p)
               8:       b = opcode[7:0];
               9:       b = opcode[15:8];
               14:      b = univ[7:0];
               15:      b = {1'($urandom), univ[14:8]};
               16:      b = declared[15:8];
               17:      b = declared[7:0];
               default: b = 8'($urandom);
            endcase
         end
         queue_byte(b, p == total - 1);
      end
   endtask

   task automatic queue_random_packet();
      int pick;
      int cap;
      int total;
      int n;
      logic [15:0] declared;
      logic [adr_pkg::UNIV_W-1:0] univ;
      bit bad_id;
      bit bad_op;
      pick = $urandom_range(0, 99);
      univ = listen_copy;
      bad_id = 1'b0;
      bad_op = 1'b0;
      if (pick >= 94) begin
         n = $urandom_range(1, 40);
         for (int p = 0; p < n; p++)
            queue_byte(8'($urandom), p == n - 1);
         return;
      end
      case ($urandom_range(0, 79))
         0:       declared = 16'($urandom_range(500, 512));
         1:       declared = 16'($urandom_range(513, 65535));
         default: declared = 16'($urandom_range(0, 24));
      endcase
      if (pick >= 50 && pick < 60 && declared == 16'd0)
         declared = 16'($urandom_range(1, 24));
      cap = (declared > adr_pkg::CHANNELS) ? adr_pkg::CHANNELS : int'(declared);
      total = adr_pkg::HEADER_BYTES + cap;
      if (pick >= 50) begin
         if (pick < 60) begin
            total = adr_pkg::HEADER_BYTES + $urandom_range(0, cap - 1);
         end else if (pick < 67) begin
            total = $urandom_range(1, adr_pkg::HEADER_BYTES - 1);
         end else if (pick < 73) begin
            bad_id = 1'b1;
         end else if (pick < 79) begin
            bad_op = 1'b1;
         end else if (pick < 85) begin
            univ = univ ^ (adr_pkg::UNIV_W'(1) << $urandom_range(0, adr_pkg::UNIV_W - 1));
         end else if (pick < 90) begin
            total = total + $urandom_range(1, 20);
         end else begin
            bad_id = 1'($urandom);
            bad_op = 1'($urandom);
            univ = univ ^ adr_pkg::UNIV_W'($urandom);
            total = $urandom_range(1, total);
         end
      end
      queue_packet(total, declared, univ, bad_id, bad_op);
   endtask

   task automatic set_listen_universe(input logic [adr_pkg::UNIV_W-1:0] u);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= u;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      listen_copy = u;
   endtask

   task automatic wait_drained();
      while (items_accepted != items_queued || awaited_reports.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   always @(posedge clock) begin : feed_requests
      rx_item_type fresh;
      if (reset) begin
         req_ch.valid <= 1'b0;
         feed_gap = 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (feed_gap != 0 || byte_stream.size() == 0) begin
            req_ch.valid <= 1'b0;
            if (feed_gap != 0)
               feed_gap--;
         end else begin
            fresh = byte_stream.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.operation <= fresh.op;
            req_ch.data_byte <= fresh.data_byte;
            req_ch.last_byte <= fresh.last_byte;
            req_ch.channel_index <= fresh.channel_index;
            if ($urandom_range(0, 29) == 0)
               feed_calm = !feed_calm;
            feed_gap = feed_calm ? 0 : $urandom_range(0, 13);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         drain_stall = 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         if ($urandom_range(0, 29) == 0)
            drain_calm = !drain_calm;
         drain_stall = drain_calm ? 0 : $urandom_range(0, 13);
         rsp_ch.ready <= (drain_stall == 0);
      end else if (drain_stall != 0) begin
         drain_stall--;
         rsp_ch.ready <= (drain_stall == 0);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : watch_ports
      rx_report_type want;
      rx_item_type seen;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: done=%0d reason=%0d len=%0d value=%0d active=%0d",
                           rsp_ch.packet_done, rsp_ch.reject_reason, rsp_ch.frame_length,
                           rsp_ch.channel_value, rsp_ch.receiver_active);
            end else begin
               want = awaited_reports.pop_front();
               if (rsp_ch.packet_done !== want.done || rsp_ch.reject_reason !== want.reason ||
                   rsp_ch.frame_length !== want.frame_length ||
                   rsp_ch.channel_value !== want.channel_value ||
                   rsp_ch.receiver_active !== want.active) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: expected done=%0d reason=%0d len=%0d value=%0d active=%0d",
                              want.done, want.reason, want.frame_length, want.channel_value,
                              want.active);
                     $display("          actual   done=%0d reason=%0d len=%0d value=%0d active=%0d",
                              rsp_ch.packet_done, rsp_ch.reject_reason, rsp_ch.frame_length,
                              rsp_ch.channel_value, rsp_ch.receiver_active);
                  end
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            seen.op = adr_pkg::adr_op_type'(req_ch.operation);
            seen.data_byte = req_ch.data_byte;
            seen.last_byte = req_ch.last_byte;
            seen.channel_index = req_ch.channel_index;
            predict_item(seen);
            items_accepted++;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin : run_stimulus
      logic [adr_pkg::UNIV_W-1:0] plan [0:4];
      int phase_start;
      req_ch.valid = 1'b0;
      req_ch.operation = adr_pkg::OP_BYTE;
      req_ch.data_byte = 8'h00;
      req_ch.last_byte = 1'b0;
      req_ch.channel_index = 9'd0;
      rsp_ch.ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      shadow_bank = 1'b0;
      shadow_length = '0;
      shadow_active = 1'b0;
      pkt_pos = 0;
      pkt_id_ok = 1'b1;
      pkt_opcode = '0;
      pkt_universe = '0;
      pkt_declared = '0;
      listen_copy = '0;
      plan[0] = '0;
      plan[1] = 15'h7FFF;
      plan[2] = adr_pkg::UNIV_W'($urandom);
      plan[3] = 15'd1;
      plan[4] = adr_pkg::UNIV_W'($urandom);

      read_mix = 0;
      queue_read(9'd0);
      queue_packet(1, 16'd0, 15'd0, 1'b0, 1'b0);
      queue_packet(adr_pkg::HEADER_BYTES, 16'd0, 15'd0, 1'b0, 1'b0);
      queue_packet(adr_pkg::HEADER_BYTES + 3, 16'd3, 15'd0, 1'b0, 1'b0);
      queue_read(9'd0);
      queue_read(9'd2);
      queue_read(9'd3);
      queue_read(9'h1FF);
      queue_packet(adr_pkg::HEADER_BYTES + 2, 16'd2, 15'd0, 1'b1, 1'b0);
      queue_packet(adr_pkg::HEADER_BYTES + 2, 16'd2, 15'd0, 1'b0, 1'b1);
      queue_packet(adr_pkg::HEADER_BYTES + 2, 16'd2, 15'h7FFF, 1'b0, 1'b0);
      queue_packet(adr_pkg::HEADER_BYTES + 1, 16'd4, 15'd0, 1'b0, 1'b0);
      queue_packet(adr_pkg::HEADER_BYTES - 1, 16'd0, 15'd0, 1'b0, 1'b0);
      queue_packet(30, 16'h0201, 15'd0, 1'b0, 1'b0);
      queue_packet(adr_pkg::HEADER_BYTES + 2, 16'd2, 15'h0001, 1'b1, 1'b1);
      queue_read(9'd1);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 5; phase++) begin
         if (phase > 0) begin
            wait_drained();
            set_listen_universe(plan[phase]);
         end
         read_mix = 0;
         if (phase == 1) begin
            // full frame with an over-range length and trailing bytes past the limit
            queue_packet(adr_pkg::MAX_PACKET_BYTES + 4, 16'hFFFF, listen_copy, 1'b0, 1'b0);
            queue_read(9'h1FF);
            queue_read(9'd0);
            queue_read(9'h100);
         end
         read_mix = 10;
         phase_start = items_queued;
         while (items_queued - phase_start < PHASE_ITEMS)
            queue_random_packet();
      end

      wait_drained();
      if (mismatches == 0 && awaited_reports.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
